[design/lcma_pkg.sv]
// ----------------------------------------------------------------------------
// lcma_pkg: shared types and constants of the load cell moving average
// Widths, register indexes, state types and divider request/response structs.
// ----------------------------------------------------------------------------
package lcma_pkg;

    localparam int WINDOW   = 35;
    localparam int SAMPLE_W = 24;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int GAIN_W   = 32;
    localparam int PROD_W   = DIFF_W + GAIN_W;
    localparam int FRAC_W   = 16;
    localparam int SHIFT_W  = PROD_W - FRAC_W;
    localparam int WEIGHT_W = 32;
    localparam int TOTAL_W  = 38;
    localparam int COUNT_W  = 32;
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 2;
    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int ITER_W   = $clog2(TOTAL_W);

    localparam logic signed [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

    typedef logic [INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_TARE = cfg_index_t'(0);
    localparam cfg_index_t REG_GAIN = cfg_index_t'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_WRITE
    } lcma_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    typedef struct packed {
        logic                       start;
        logic signed [TOTAL_W-1:0]  dividend;
        logic [CNT_W-1:0]           divisor;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic [WEIGHT_W-1:0]        quotient;
    } div_resp_t;

endpackage

[design/lcma_cfg_if.sv]
// ----------------------------------------------------------------------------
// lcma_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface lcma_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lcma_pkg::INDEX_W-1:0]    index;
    logic [lcma_pkg::DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/lcma_sample_if.sv]
// ----------------------------------------------------------------------------
// lcma_sample_if: ADC sample channel
// Valid/ready channel carrying one signed ADC sample per request.
// ----------------------------------------------------------------------------
interface lcma_sample_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lcma_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[design/lcma_result_if.sv]
// ----------------------------------------------------------------------------
// lcma_result_if: weight result channel
// Valid/ready channel carrying raw weight, filtered weight and sample count.
// ----------------------------------------------------------------------------
interface lcma_result_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [lcma_pkg::WEIGHT_W-1:0]  raw_weight;
    logic signed [lcma_pkg::WEIGHT_W-1:0]  filtered_weight;
    logic [lcma_pkg::COUNT_W-1:0]          samples_seen;

    modport source (output valid, output raw_weight, output filtered_weight,
                    output samples_seen, input ready);
    modport sink   (input valid, input raw_weight, input filtered_weight,
                    input samples_seen, output ready);
endinterface

[design/lcma_ram.sv]
// ----------------------------------------------------------------------------
// lcma_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lcma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/lcma_divider.sv]
// ----------------------------------------------------------------------------
// lcma_divider: iterative signed divider for the window mean
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module lcma_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcma_pkg::div_req_t   req,
    output lcma_pkg::div_resp_t  resp
);

    lcma_pkg::div_state_t               state_reg, state_next;
    logic                               neg_reg, neg_next;
    logic [lcma_pkg::TOTAL_W-1:0]       quo_reg, quo_next;
    logic [lcma_pkg::CNT_W-1:0]         rem_reg, rem_next;
    logic [lcma_pkg::CNT_W-1:0]         divisor_reg, divisor_next;
    logic [lcma_pkg::ITER_W-1:0]        iter_reg, iter_next;

    logic [lcma_pkg::TOTAL_W-1:0]       magnitude;
    logic [lcma_pkg::CNT_W:0]           rem_shift;
    logic [lcma_pkg::CNT_W:0]           rem_diff;

    assign magnitude = req.dividend[lcma_pkg::TOTAL_W-1]
                       ? lcma_pkg::TOTAL_W'(-req.dividend)
                       : lcma_pkg::TOTAL_W'(req.dividend);
    assign rem_shift = {rem_reg, quo_reg[lcma_pkg::TOTAL_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcma_pkg::DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        iter_reg    <= iter_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        neg_next     = neg_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        iter_next    = iter_reg;
        case (state_reg)
            lcma_pkg::DIV_IDLE:
            begin
                if (req.start)
                begin
                    neg_next     = req.dividend[lcma_pkg::TOTAL_W-1];
                    quo_next     = magnitude;
                    rem_next     = '0;
                    divisor_next = req.divisor;
                    iter_next    = lcma_pkg::ITER_W'(lcma_pkg::TOTAL_W - 1);
                    state_next   = lcma_pkg::DIV_RUN;
                end
            end
            lcma_pkg::DIV_RUN:
            begin
                if (rem_shift >= {1'b0, divisor_reg})
                begin
                    rem_next = rem_diff[lcma_pkg::CNT_W-1:0];
                    quo_next = {quo_reg[lcma_pkg::TOTAL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[lcma_pkg::CNT_W-1:0];
                    quo_next = {quo_reg[lcma_pkg::TOTAL_W-2:0], 1'b0};
                end
                if (iter_reg == '0)
                begin
                    state_next = lcma_pkg::DIV_DONE;
                end
                else
                begin
                    iter_next = iter_reg - 1'b1;
                end
            end
            lcma_pkg::DIV_DONE:
            begin
                state_next = lcma_pkg::DIV_IDLE;
            end
            default:
            begin
                state_next = lcma_pkg::DIV_IDLE;
            end
        endcase
    end

    assign resp.done     = (state_reg == lcma_pkg::DIV_DONE);
    assign resp.quotient = neg_reg ? -quo_reg[lcma_pkg::WEIGHT_W-1:0]
                                   : quo_reg[lcma_pkg::WEIGHT_W-1:0];

endmodule

[design/load_cell_moving_average.sv]
// ----------------------------------------------------------------------------
// load_cell_moving_average: tared, scaled and boxcar-averaged load cell weight
// One sample at a time: the next is accepted only after the 38-step iterative divider and the result write.
// Ready drops while a sample is in flight; a waiting result holds it in its last cycle.
// Reset: async active-low; tare 0, gain 1.0, window empty, counter zero.
// Ring entries not yet written read as zero until the window first fills.
// ----------------------------------------------------------------------------
module load_cell_moving_average (
    input  logic                  clk,
    input  logic                  rst_n,
    lcma_cfg_if.sink              cfg,
    lcma_sample_if.sink           samples,
    lcma_result_if.source         results
);

    lcma_pkg::lcma_state_t                  state_reg, state_next;

    logic signed [lcma_pkg::SAMPLE_W-1:0]   tare_reg;
    logic signed [lcma_pkg::GAIN_W-1:0]     gain_reg;

    logic signed [lcma_pkg::DIFF_W-1:0]     diff_reg;
    logic signed [lcma_pkg::PROD_W-1:0]     prod_reg;
    logic signed [lcma_pkg::TOTAL_W-1:0]    total_reg, total_next;
    logic [lcma_pkg::SLOT_W-1:0]            slot_reg, slot_next;
    logic                                   full_reg, full_next;
    logic [lcma_pkg::COUNT_W-1:0]           counter_reg, counter_next;
    logic signed [lcma_pkg::WEIGHT_W-1:0]   raw_reg, raw_next;
    logic [lcma_pkg::WEIGHT_W-1:0]          mean_reg;

    logic                                   out_valid_reg, out_valid_next;
    logic signed [lcma_pkg::WEIGHT_W-1:0]   out_raw_reg;
    logic signed [lcma_pkg::WEIGHT_W-1:0]   out_mean_reg;
    logic [lcma_pkg::COUNT_W-1:0]           out_count_reg;

    logic                                   accept;
    logic                                   load_out;
    logic signed [lcma_pkg::SHIFT_W-1:0]    shifted;
    logic signed [lcma_pkg::WEIGHT_W-1:0]   sat_weight;
    logic [lcma_pkg::WEIGHT_W-1:0]          ram_q;
    logic signed [lcma_pkg::WEIGHT_W-1:0]   old_weight;
    logic                                   ram_we;
    logic [lcma_pkg::CNT_W-1:0]             divisor;

    lcma_pkg::div_req_t                     div_req;
    lcma_pkg::div_resp_t                    div_resp;

    assign cfg.ready     = 1'b1;
    assign samples.ready = (state_reg == lcma_pkg::ST_IDLE);
    assign accept        = samples.valid && samples.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_reg <= '0;
            gain_reg <= lcma_pkg::GAIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                lcma_pkg::REG_TARE: tare_reg <= cfg.data[lcma_pkg::SAMPLE_W-1:0];
                lcma_pkg::REG_GAIN: gain_reg <= cfg.data[lcma_pkg::GAIN_W-1:0];
                default:            ;
            endcase
        end
    end

    // floor shift and saturate
    assign shifted = prod_reg[lcma_pkg::PROD_W-1:lcma_pkg::FRAC_W];

    always_comb
    begin
        if (shifted[lcma_pkg::SHIFT_W-1:lcma_pkg::WEIGHT_W-1] == '0 ||
            shifted[lcma_pkg::SHIFT_W-1:lcma_pkg::WEIGHT_W-1] == '1)
        begin
            sat_weight = shifted[lcma_pkg::WEIGHT_W-1:0];
        end
        else if (shifted[lcma_pkg::SHIFT_W-1])
        begin
            sat_weight = {1'b1, {(lcma_pkg::WEIGHT_W-1){1'b0}}};
        end
        else
        begin
            sat_weight = {1'b0, {(lcma_pkg::WEIGHT_W-1){1'b1}}};
        end
    end

    lcma_ram #(
        .WIDTH (lcma_pkg::WEIGHT_W),
        .DEPTH (lcma_pkg::WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (sat_weight),
        .re    (accept),
        .raddr (slot_reg),
        .rdata (ram_q)
    );

    assign old_weight = full_reg ? ram_q : '0;

    assign divisor = full_reg ? lcma_pkg::CNT_W'(lcma_pkg::WINDOW)
                   : ((slot_reg == '0) ? lcma_pkg::CNT_W'(1)
                                       : lcma_pkg::CNT_W'(slot_reg));

    assign div_req.start    = (state_reg == lcma_pkg::ST_START);
    assign div_req.dividend = total_reg;
    assign div_req.divisor  = divisor;

    lcma_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcma_pkg::ST_IDLE;
            total_reg     <= '0;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            counter_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            slot_reg      <= slot_next;
            full_reg      <= full_next;
            counter_reg   <= counter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_reg <= lcma_pkg::DIFF_W'(samples.sample) - lcma_pkg::DIFF_W'(tare_reg);
        end
        if (state_reg == lcma_pkg::ST_SCALE)
        begin
            prod_reg <= diff_reg * gain_reg;
        end
        raw_reg <= raw_next;
        if (div_resp.done)
        begin
            mean_reg <= div_resp.quotient;
        end
        if (load_out)
        begin
            out_raw_reg   <= raw_reg;
            out_mean_reg  <= mean_reg;
            out_count_reg <= counter_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        slot_next      = slot_reg;
        full_next      = full_reg;
        counter_next   = counter_reg;
        raw_next       = raw_reg;
        ram_we         = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg;
        if (results.valid && results.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            lcma_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = lcma_pkg::ST_SCALE;
                end
            end
            lcma_pkg::ST_SCALE:
            begin
                total_next = total_reg - lcma_pkg::TOTAL_W'(old_weight);
                state_next = lcma_pkg::ST_UPDATE;
            end
            lcma_pkg::ST_UPDATE:
            begin
                ram_we       = 1'b1;
                raw_next     = sat_weight;
                total_next   = total_reg + lcma_pkg::TOTAL_W'(sat_weight);
                counter_next = counter_reg + 1'b1;
                if (slot_reg >= lcma_pkg::SLOT_W'(lcma_pkg::WINDOW - 1))
                begin
                    slot_next = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    slot_next = slot_reg + 1'b1;
                end
                state_next = lcma_pkg::ST_START;
            end
            lcma_pkg::ST_START:
            begin
                state_next = lcma_pkg::ST_DIVIDE;
            end
            lcma_pkg::ST_DIVIDE:
            begin
                if (div_resp.done)
                begin
                    state_next = lcma_pkg::ST_WRITE;
                end
            end
            lcma_pkg::ST_WRITE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = lcma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcma_pkg::ST_IDLE;
            end
        endcase
    end

    assign results.valid           = out_valid_reg;
    assign results.raw_weight      = out_raw_reg;
    assign results.filtered_weight = out_mean_reg;
    assign results.samples_seen    = out_count_reg;

endmodule
